// ----- hdl/assert_macros.svh -----
// Assertion shorthands for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCIT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// The consequent must hold in the cycle after the antecedent.
`define MCIT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

// The expression must never be true.
`define MCIT_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition observed");

`endif

// ----- hdl/mcit_pkg.sv -----
`timescale 1ns / 1ps

package mcit_pkg;

    localparam int NUM_CHANNELS = 5;
    localparam int WORD_COUNT   = 5;

    localparam int WORD_W    = 13;
    localparam int REM_W     = 13;
    localparam int CH_W      = 3;
    localparam int EV_W      = 3;
    localparam int PAT_W     = 3;
    localparam int TAP_W     = 3;
    localparam int OP_W      = 2;
    localparam int ADDR_W    = 3;
    localparam int VAL_W     = 7;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    localparam int BUF_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int BUF_CNT_W = $clog2(NUM_CHANNELS + 1);

    localparam logic [REM_W-1:0] HOUR_SECS = 13'd3600;

    localparam logic [1:0] MODE_MINUTES = 2'd1;
    localparam logic [1:0] MODE_SECONDS = 2'd2;

    localparam logic [WORD_W-1:0] WORD_RESET [WORD_COUNT] =
        '{13'd42, 13'd1066, 13'd2090, 13'd3114, 13'd4138};

    typedef enum logic [OP_W-1:0] {
        OP_TICK,
        OP_TOGGLE,
        OP_TAP,
        OP_EXPIRE
    } op_t;

    typedef enum logic [EV_W-1:0] {
        EV_NONE,
        EV_FIRED,
        EV_STARTED,
        EV_STOPPED,
        EV_CFGREQ
    } ev_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_EMIT
    } state_t;

    // Outcome of one pass of the channel step unit.
    typedef struct packed {
        logic              upd_rem;
        logic [REM_W-1:0]  rem_val;
        logic              upd_run;
        logic              run_val;
        logic              has_ev;
        ev_t               ev;
        logic [PAT_W-1:0]  pattern;
    } step_res_t;

    typedef struct packed {
        ev_t               ev;
        logic [CH_W-1:0]   chan;
        logic [PAT_W-1:0]  pattern;
    } event_t;

    // Reload value of a channel; value*60 is formed as value*64 - value*4.
    function automatic logic [REM_W-1:0] interval_of(input logic [WORD_W-1:0] word);
        logic [1:0]       mode;
        logic [VAL_W-1:0] val;
        logic [REM_W-1:0] res;
        mode = word[2:1];
        val  = word[9:3];
        case (mode)
            MODE_MINUTES: begin
                res = {val, 6'b0} - {4'b0, val, 2'b0};
            end
            MODE_SECONDS: begin
                res = {6'b0, val};
            end
            default: begin
                res = HOUR_SECS;
            end
        endcase
        return res;
    endfunction

endpackage

// ----- hdl/mcit_step_unit.sv -----
`timescale 1ns / 1ps

module mcit_step_unit (
    input  logic [mcit_pkg::WORD_W-1:0] word,
    input  logic [mcit_pkg::REM_W-1:0]  rem,
    input  logic                        run,
    input  logic                        is_tick,
    output mcit_pkg::step_res_t         res
);

    logic [mcit_pkg::REM_W-1:0] reload;
    logic [mcit_pkg::REM_W-1:0] dec;

    assign reload = mcit_pkg::interval_of(word);
    assign dec    = (rem == '0) ? '0 : rem - 1'b1;

    always_comb begin
        res         = '0;
        res.ev      = mcit_pkg::EV_NONE;
        res.rem_val = reload;
        if (is_tick) begin
            // A zero interval reloads to zero, so the channel fires on every tick.
            if (run) begin
                res.upd_rem = 1'b1;
                if (dec == '0) begin
                    res.has_ev  = 1'b1;
                    res.ev      = mcit_pkg::EV_FIRED;
                    res.pattern = word[12:10];
                end else begin
                    res.rem_val = dec;
                end
            end
        end else begin
            res.has_ev = 1'b1;
            if (!word[0]) begin
                res.ev = mcit_pkg::EV_CFGREQ;
            end else if (run) begin
                res.upd_run = 1'b1;
                res.run_val = 1'b0;
                res.ev      = mcit_pkg::EV_STOPPED;
            end else begin
                res.upd_run = 1'b1;
                res.run_val = 1'b1;
                res.upd_rem = 1'b1;
                res.ev      = mcit_pkg::EV_STARTED;
            end
        end
    end

endmodule

// ----- hdl/mcit_evt_buf.sv -----
`timescale 1ns / 1ps

module mcit_evt_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 clear,
    input  logic                 push,
    input  mcit_pkg::event_t     push_evt,
    input  logic                 pop,
    output mcit_pkg::event_t     head,
    output logic                 head_last
);

    mcit_pkg::event_t entries_reg [mcit_pkg::NUM_CHANNELS];

    logic [mcit_pkg::BUF_CNT_W-1:0] count_reg;
    logic [mcit_pkg::BUF_CNT_W-1:0] count_next;
    logic [mcit_pkg::BUF_IDX_W-1:0] rd_ptr_reg;
    logic [mcit_pkg::BUF_IDX_W-1:0] rd_ptr_next;

    always_comb begin
        count_next  = count_reg;
        rd_ptr_next = rd_ptr_reg;
        if (clear) begin
            count_next  = '0;
            rd_ptr_next = '0;
        end else begin
            if (push) begin
                count_next = count_reg + 1'b1;
            end
            if (pop && !head_last) begin
                rd_ptr_next = rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            rd_ptr_reg <= '0;
        end else begin
            count_reg  <= count_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !clear) begin
            entries_reg[count_reg[mcit_pkg::BUF_IDX_W-1:0]] <= push_evt;
        end
    end

    // An input that produced no event still yields one empty result.
    always_comb begin
        if (count_reg == '0) begin
            head         = '0;
            head.ev      = mcit_pkg::EV_NONE;
            head_last    = 1'b1;
        end else begin
            head         = entries_reg[rd_ptr_reg];
            head_last    = (mcit_pkg::BUF_CNT_W'(rd_ptr_reg) + 1'b1) == count_reg;
        end
    end

endmodule

// ----- hdl/multi_channel_interval_timer.sv -----
`timescale 1ns / 1ps

// Five-channel interval timer. One request is taken at a time. A single channel
// step unit serves every channel in turn: a tick request is accepted, walks the
// channels in order, and then offers its results (1 to NUM_CHANNELS results) one
// after another; a toggle, tap or tap-window-expiry request yields a single
// result. Results wait in a small event buffer until the sink takes them; the
// last one carries m_tlast, and every result of a request shows the timer state
// after it. Configuration words take effect at once, so write them only while no
// request is in flight; a word changed during a tick walk is seen by the steps
// still to come.
module multi_channel_interval_timer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // channel[2:0], zero above
    input  logic [mcit_pkg::S_TDATA_W-1:0]  s_tdata,
    // opcode[1:0]
    input  logic [mcit_pkg::OP_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // event_channel[2:0], pattern[5:3], any_active[6], armed[7], taps[10:8]
    output logic [mcit_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tlast,
    // event_res[2:0]
    output logic [mcit_pkg::EV_W-1:0]       m_tuser,
    input  logic                            cfg_we,
    input  logic [mcit_pkg::ADDR_W-1:0]     cfg_addr,
    input  logic [mcit_pkg::WORD_W-1:0]     cfg_wdata
);

    localparam logic [mcit_pkg::CH_W-1:0]  LAST_CH =
        mcit_pkg::CH_W'(mcit_pkg::NUM_CHANNELS - 1);
    localparam logic [mcit_pkg::TAP_W-1:0] TAP_MAX = mcit_pkg::TAP_W'(mcit_pkg::NUM_CHANNELS);

    mcit_pkg::state_t state_reg, state_next;
    mcit_pkg::op_t    op_reg, op_next;

    logic [mcit_pkg::CH_W-1:0]   idx_reg, idx_next;
    logic                        step_en_reg, step_en_next;
    logic                        tap_open_reg, tap_open_next;
    logic [mcit_pkg::TAP_W-1:0]  tap_tally_reg, tap_tally_next;

    logic [mcit_pkg::WORD_W-1:0] word_reg [mcit_pkg::WORD_COUNT];
    logic [mcit_pkg::REM_W-1:0]  rem_reg  [mcit_pkg::WORD_COUNT];
    logic                        run_reg  [mcit_pkg::WORD_COUNT];

    logic                        s_accept;
    logic                        walk_done;
    logic                        step_go;
    logic                        buf_push;
    logic                        buf_pop;
    logic                        any_active;
    mcit_pkg::op_t               s_op;
    logic [mcit_pkg::CH_W-1:0]   s_chan;
    mcit_pkg::step_res_t         step_res;
    mcit_pkg::event_t            push_evt;
    mcit_pkg::event_t            head;
    logic                        head_last;

    assign s_op      = mcit_pkg::op_t'(s_tuser);
    assign s_chan    = s_tdata[mcit_pkg::CH_W-1:0];
    assign s_accept  = s_tvalid && s_tready;
    assign walk_done = (op_reg != mcit_pkg::OP_TICK) || (idx_reg == LAST_CH);

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mcit_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = mcit_pkg::ST_WALK;
                end
            end
            mcit_pkg::ST_WALK: begin
                if (walk_done) begin
                    state_next = mcit_pkg::ST_EMIT;
                end
            end
            mcit_pkg::ST_EMIT: begin
                if (m_tready && head_last) begin
                    state_next = mcit_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mcit_pkg::ST_IDLE;
            end
        endcase
    end

    // State-decoded outputs.
    always_comb begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        step_go  = 1'b0;
        case (state_reg)
            mcit_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            mcit_pkg::ST_WALK: begin
                step_go = step_en_reg;
            end
            mcit_pkg::ST_EMIT: begin
                m_tvalid = 1'b1;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Request decode and channel walk. Tap bookkeeping completes at acceptance.
    always_comb begin
        op_next        = op_reg;
        idx_next       = idx_reg;
        step_en_next   = step_en_reg;
        tap_open_next  = tap_open_reg;
        tap_tally_next = tap_tally_reg;
        if (s_accept) begin
            op_next = s_op;
            case (s_op)
                mcit_pkg::OP_TICK: begin
                    idx_next     = '0;
                    step_en_next = 1'b1;
                end
                mcit_pkg::OP_TOGGLE: begin
                    idx_next     = s_chan;
                    step_en_next = s_chan < LAST_CH + 1'b1;
                end
                mcit_pkg::OP_TAP: begin
                    step_en_next = 1'b0;
                    if (!tap_open_reg) begin
                        tap_open_next  = 1'b1;
                        tap_tally_next = '0;
                    end else if (tap_tally_reg < TAP_MAX) begin
                        tap_tally_next = tap_tally_reg + 1'b1;
                    end
                end
                mcit_pkg::OP_EXPIRE: begin
                    // The tally selects channel tally-1; a zero tally toggles nothing.
                    idx_next       = mcit_pkg::CH_W'(tap_tally_reg - 1'b1);
                    step_en_next   = tap_tally_reg inside {[mcit_pkg::TAP_W'(1):TAP_MAX]};
                    tap_open_next  = 1'b0;
                    tap_tally_next = '0;
                end
                default: begin
                    step_en_next = 1'b0;
                end
            endcase
        end else if (state_reg == mcit_pkg::ST_WALK && !walk_done) begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mcit_pkg::ST_IDLE;
            op_reg        <= mcit_pkg::OP_TICK;
            idx_reg       <= '0;
            step_en_reg   <= 1'b0;
            tap_open_reg  <= 1'b0;
            tap_tally_reg <= '0;
        end else begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            idx_reg       <= idx_next;
            step_en_reg   <= step_en_next;
            tap_open_reg  <= tap_open_next;
            tap_tally_reg <= tap_tally_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mcit_pkg::WORD_COUNT; i++) begin
                word_reg[i] <= mcit_pkg::WORD_RESET[i];
                rem_reg[i]  <= '0;
                run_reg[i]  <= 1'b0;
            end
        end else begin
            if (cfg_we && cfg_addr < mcit_pkg::ADDR_W'(mcit_pkg::WORD_COUNT)) begin
                word_reg[cfg_addr] <= cfg_wdata;
            end
            if (step_go && step_res.upd_rem) begin
                rem_reg[idx_reg] <= step_res.rem_val;
            end
            if (step_go && step_res.upd_run) begin
                run_reg[idx_reg] <= step_res.run_val;
            end
        end
    end

    mcit_step_unit u_step (
        .word    (word_reg[idx_reg]),
        .rem     (rem_reg[idx_reg]),
        .run     (run_reg[idx_reg]),
        .is_tick (op_reg == mcit_pkg::OP_TICK),
        .res     (step_res)
    );

    assign buf_push         = step_go && step_res.has_ev;
    assign buf_pop          = m_tvalid && m_tready;
    assign push_evt.ev      = step_res.ev;
    assign push_evt.chan    = idx_reg;
    assign push_evt.pattern = step_res.pattern;

    mcit_evt_buf u_evt_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (s_accept),
        .push      (buf_push),
        .push_evt  (push_evt),
        .pop       (buf_pop),
        .head      (head),
        .head_last (head_last)
    );

    always_comb begin
        any_active = 1'b0;
        for (int i = 0; i < mcit_pkg::NUM_CHANNELS; i++) begin
            any_active = any_active | run_reg[i];
        end
    end

    assign m_tdata = {5'b0, tap_tally_reg, tap_open_reg, any_active,
                      head.pattern, head.chan};
    assign m_tuser = head.ev;
    assign m_tlast = head_last;

endmodule

// ----- hdl/mcit_checker.sv -----
`timescale 1ns / 1ps

`include "assert_macros.svh"

module mcit_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [mcit_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                            m_tlast,
    input logic [mcit_pkg::EV_W-1:0]       m_tuser
);

    // A waiting result keeps its contents until taken.
    `MCIT_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // The block never takes a request while results are still being offered.
    `MCIT_ASSERT_NEVER(a_no_overlap, aclk, aresetn, s_tready && m_tvalid)

    // In the cycle after a request is taken, the block neither takes a request nor offers a result.
    `MCIT_ASSERT_NXT(a_busy_after_req, aclk, aresetn, s_tvalid && s_tready, !s_tready && !m_tvalid)

    // The final result of a request ends the run of results.
    `MCIT_ASSERT_NXT(a_last_ends, aclk, aresetn, m_tvalid && m_tready && m_tlast, !m_tvalid && s_tready)

    // An empty result always carries m_tlast, as the last result of its request.
    `MCIT_ASSERT_IMP(a_none_is_last, aclk, aresetn, m_tvalid && (m_tuser == mcit_pkg::EV_NONE), m_tlast)

endmodule

bind multi_channel_interval_timer mcit_checker u_mcit_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
